// ----- sv/absmax_int8_scale_defines.svh -----
// Assertion macros for the checks in the top-level file of this block.
`ifndef ABSMAX_INT8_SCALE_DEFINES_SVH
`define ABSMAX_INT8_SCALE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AMX_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AMX_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/amx_pkg.sv -----
`default_nettype none
package amx_pkg;

   localparam int unsigned MAX_LEN     = 8192;
   localparam int unsigned COUNT_W     = $clog2(MAX_LEN + 1);
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [30:0] EXP_ALL_ONES = 31'h7F80_0000;
   localparam logic [31:0] QNAN_BITS    = 32'h7FC0_0000;
   localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
   localparam logic [31:0] ZERO_BITS    = 32'h0000_0000;
   localparam logic [7:0]  DIVISOR      = 8'd127;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_TOO_LONG = 1'b1;

   // One finished token as handed from the front to the back.
   typedef struct packed {
      logic        too_long;
      logic        seen_number;
      logic [30:0] max_magnitude;
   } amx_token_type;

   typedef struct packed {
      logic full;
      logic empty;
   } amx_qstat_type;

endpackage
`default_nettype wire

// ----- sv/amx_if.sv -----
`default_nettype none
interface amx_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] activation;
   logic        last;
   modport source (output valid, output activation, output last, input ready);
   modport sink   (input valid, input activation, input last, output ready);
endinterface

interface amx_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] scale;
   logic        status;
   modport source (output valid, output scale, output status, input ready);
   modport sink   (input valid, input scale, input status, output ready);
endinterface
`default_nettype wire

// ----- sv/amx_front.sv -----
`default_nettype none
module amx_front (
   input  wire logic            clock,
   input  wire logic            reset,
   amx_req_if.sink              req,
   input  wire logic            q_full,
   output logic                 push,
   output amx_pkg::amx_token_type push_data
);
   import amx_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               too_long_ff, too_long_in;
   logic               seen_ff, seen_in;
   logic [30:0]        max_ff, max_in;
   logic [30:0]        mag;
   logic               accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign mag       = req.activation[30:0];

   always_comb begin
      count_in    = count_ff;
      too_long_in = too_long_ff;
      seen_in     = seen_ff;
      max_in      = max_ff;
      if (accept) begin
         if (count_ff >= COUNT_W'(MAX_LEN)) begin
            too_long_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
         // NaN patterns lie above the infinity pattern and are skipped.
         if (mag <= EXP_ALL_ONES) begin
            if (!seen_ff || mag > max_ff) begin
               max_in = mag;
            end
            seen_in = 1'b1;
         end
      end
      push_data = '{too_long: too_long_in, seen_number: seen_in, max_magnitude: max_in};
      push      = accept && req.last;
      if (push) begin
         count_in    = '0;
         too_long_in = 1'b0;
         seen_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      max_ff <= max_in;
      if (reset) begin
         count_ff    <= '0;
         too_long_ff <= 1'b0;
         seen_ff     <= 1'b0;
      end else begin
         count_ff    <= count_in;
         too_long_ff <= too_long_in;
         seen_ff     <= seen_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/amx_queue.sv -----
`default_nettype none
module amx_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire amx_pkg::amx_token_type push_data,
   input  wire logic                   pop,
   output amx_pkg::amx_token_type      pop_data,
   output amx_pkg::amx_qstat_type      qstat
);
   import amx_pkg::*;

   amx_token_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]        fill_ff, fill_in;

   assign qstat.full  = (fill_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign qstat.empty = (fill_ff == '0);
   assign pop_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/amx_back.sv -----
`default_nettype none
module amx_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire amx_pkg::amx_token_type pop_data,
   input  wire amx_pkg::amx_qstat_type qstat,
   output logic                        pop,
   amx_rsp_if.source                   rsp
);
   import amx_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_NORM, ST_DIV, ST_FIX, ST_ROUND, ST_EMIT
   } state_type;

   state_type          state_ff;
   logic [23:0]        sig_ff;
   logic signed [9:0]  exp_ff;
   logic [32:0]        num_ff;
   logic [26:0]        quo_ff;
   logic [6:0]         rem_ff;
   logic [31:0]        res_ff;
   logic               res_status_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_scale_ff;
   logic               rsp_status_ff;
   logic               emit_load;

   // Division by 127 = 2^7 - 1: a shift-and-add estimate that is at most
   // four short, then a remainder check that adds the missing units.
   logic [26:0]        quo_est;
   logic [33:0]        quo_x127;
   logic [33:0]        rem_wide;
   logic [9:0]         rem_est;
   logic [9:0]         rem_long;
   logic [26:0]        quo_fix;
   logic [6:0]         rem_fix;

   // Rounding of the quotient into a single.
   logic               top;
   logic signed [9:0]  eb;
   logic signed [9:0]  sh_wide;
   logic [5:0]         sh;
   logic [60:0]        wide;
   logic [26:0]        mant;
   logic               guard;
   logic               sticky;
   logic [26:0]        mant_rnd;
   logic [9:0]         eb_m1;
   logic [31:0]        packed_bits;
   logic [7:0]         exp_field;

   assign pop       = (state_ff == ST_IDLE) && !qstat.empty;
   assign exp_field = pop_data.max_magnitude[30:23];
   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      quo_est  = 27'(num_ff >> 7) + 27'(num_ff >> 14) + 27'(num_ff >> 21)
               + 27'(num_ff >> 28);
      quo_x127 = {quo_ff, 7'b0} - {7'b0, quo_ff};
      rem_wide = {1'b0, num_ff} - quo_x127;
      rem_est  = rem_wide[9:0];
      if (rem_est >= 10'(DIVISOR) * 10'd4) begin
         quo_fix  = quo_ff + 27'd4;
         rem_long = rem_est - 10'(DIVISOR) * 10'd4;
      end else if (rem_est >= 10'(DIVISOR) * 10'd3) begin
         quo_fix  = quo_ff + 27'd3;
         rem_long = rem_est - 10'(DIVISOR) * 10'd3;
      end else if (rem_est >= 10'(DIVISOR) * 10'd2) begin
         quo_fix  = quo_ff + 27'd2;
         rem_long = rem_est - 10'(DIVISOR) * 10'd2;
      end else if (rem_est >= 10'(DIVISOR)) begin
         quo_fix  = quo_ff + 27'd1;
         rem_long = rem_est - 10'(DIVISOR);
      end else begin
         quo_fix  = quo_ff;
         rem_long = rem_est;
      end
      rem_fix = rem_long[6:0];
   end

   always_comb begin
      top     = quo_ff[26];
      eb      = exp_ff + (top ? 10'sd26 : 10'sd25) - 10'sd32;
      sh_wide = (top ? 10'sd3 : 10'sd2) + ((eb < 10'sd1) ? (10'sd1 - eb) : 10'sd0);
      sh      = (sh_wide > 10'sd34) ? 6'd34 : sh_wide[5:0];
      wide    = {quo_ff, 34'b0} >> sh;
      mant    = wide[60:34];
      guard   = wide[33];
      sticky  = (|wide[32:0]) || (rem_ff != '0);
      mant_rnd = mant + 27'(guard && (sticky || mant[0]));
      eb_m1   = eb - 10'sd1;
      // A carry out of the mantissa bumps the exponent field by itself.
      if (eb >= 10'sd1) begin
         packed_bits = {1'b0, eb_m1[7:0], 23'b0} + {5'b0, mant_rnd};
      end else begin
         packed_bits = {5'b0, mant_rnd};
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.scale  = rsp_scale_ff;
   assign rsp.status = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  res_status_ff <= pop_data.too_long ? STATUS_TOO_LONG : STATUS_OK;
                  if (pop_data.too_long) begin
                     res_ff   <= ZERO_BITS;
                     state_ff <= ST_EMIT;
                  end else if (!pop_data.seen_number) begin
                     res_ff   <= QNAN_BITS;
                     state_ff <= ST_EMIT;
                  end else if (pop_data.max_magnitude == '0) begin
                     res_ff   <= ONE_BITS;
                     state_ff <= ST_EMIT;
                  end else if (exp_field == 8'hFF) begin
                     res_ff   <= {1'b0, pop_data.max_magnitude};
                     state_ff <= ST_EMIT;
                  end else begin
                     sig_ff   <= {exp_field != 8'h00, pop_data.max_magnitude[22:0]};
                     exp_ff   <= (exp_field == 8'h00) ? 10'sd1 : $signed({2'b00, exp_field});
                     state_ff <= ST_NORM;
                  end
               end
            end
            ST_NORM: begin
               if (sig_ff[23]) begin
                  num_ff   <= {sig_ff, 9'b0};
                  state_ff <= ST_DIV;
               end else begin
                  sig_ff <= {sig_ff[22:0], 1'b0};
                  exp_ff <= exp_ff - 10'sd1;
               end
            end
            ST_DIV: begin
               quo_ff   <= quo_est;
               state_ff <= ST_FIX;
            end
            ST_FIX: begin
               quo_ff   <= quo_fix;
               rem_ff   <= rem_fix;
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               res_ff   <= packed_bits;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_load) begin
                  rsp_scale_ff  <= res_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- sv/absmax_int8_scale.sv -----
// Channel   Dir  Fields                      Beat
// req_chan  in   activation[31:0], last      one activation of a token
// rsp_chan  out  scale[31:0], status         one result per token
//
// The front takes one activation beat every cycle while the token queue has room.
// The back takes a token with a normal maximum through decode, normalize check,
// quotient estimate, correction, rounding and output load, shifts once more per
// leading zero of a subnormal maximum, and goes from decode to output load for special cases.
// A two-token queue sits between front and back, so short tokens stall the input
// only when the queue is full; a stalled result waits in the output register.
// Reset is synchronous and active high and clears the running state, queue and FSM.
`default_nettype none
`include "absmax_int8_scale_defines.svh"
module absmax_int8_scale (
   input  wire logic  clock,
   input  wire logic  reset,
   amx_req_if.sink    req_chan,
   amx_rsp_if.source  rsp_chan
);
   import amx_pkg::*;

   // Front to queue: a token record is pushed on the beat that carries last.
   logic           push;
   amx_token_type  push_data;
   // Queue to back: the oldest finished token and the fill status.
   logic           pop;
   amx_token_type  pop_data;
   amx_qstat_type  qstat;
   // Terms for the checks at the end.
   logic           rsp_too_long;
   logic           rsp_scale_zero;
   logic           pop_only_full;

   // The front folds each activation into the running absolute maximum,
   // skipping NaN patterns and counting the length against the cap.
   amx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .q_full    (qstat.full),
      .push      (push),
      .push_data (push_data)
   );

   amx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   // The back divides a finite nonzero maximum by 127 with a shift-and-add estimate
   // and a small remainder correction, then rounds it to nearest even, keeping
   // subnormal results; the special cases of a token go straight to the output.
   amx_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_data (pop_data),
      .qstat    (qstat),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

   assign rsp_too_long   = rsp_chan.valid && (rsp_chan.status == STATUS_TOO_LONG);
   assign rsp_scale_zero = (rsp_chan.scale == ZERO_BITS);
   assign pop_only_full  = pop && !push && qstat.full;

   `AMX_ASSERT_IMPLY(a_no_push_when_full, push, !qstat.full, "token pushed into a full queue")
   `AMX_ASSERT_IMPLY(a_no_pop_when_empty, pop, !qstat.empty, "token popped from an empty queue")
   `AMX_ASSERT_IMPLY(a_too_long_zero, rsp_too_long, rsp_scale_zero, "too-long scale not zero")
   `AMX_ASSERT_NEXT(a_pop_frees_slot, pop_only_full, !qstat.full, "queue stays full after a pop")

endmodule
`default_nettype wire
